### hw/rtl/lpht_pkg.sv
// Shared types and constants for the linear-probing hash table.
// Used by linear_probe_hash_table and its modular multiply-accumulate unit.
// No dependencies.
package lpht_pkg;

  localparam int CHAR_W         = 8;
  localparam int KEY_CHARS      = 8;
  localparam int KEY_W          = CHAR_W * KEY_CHARS;
  localparam int KEY_LEN_W      = 4;
  localparam int TABLE_LENGTH_W = 11;
  localparam int SLOT_W         = 10;
  localparam int PROBE_COUNT_W  = 11;
  localparam int STATUS_W       = 2;

  localparam logic [CHAR_W-1:0]         HASH_MULT          = CHAR_W'(37);
  localparam logic [KEY_LEN_W-1:0]      KEY_CHARS_L        = KEY_LEN_W'(KEY_CHARS);
  localparam logic [TABLE_LENGTH_W-1:0] TABLE_LENGTH_RESET = TABLE_LENGTH_W'(1024);

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_SEARCH = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Byte mask that keeps the low n characters of a packed key.
  function automatic logic [KEY_W-1:0] key_mask(input logic [KEY_LEN_W-1:0] n);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_CHARS; b++) begin
      if (KEY_LEN_W'(b) < n) begin
        m[b*CHAR_W +: CHAR_W] = '1;
      end
    end
    return m;
  endfunction

endpackage

### hw/rtl/linear_probe_hash_table.sv
// Linear-probing hash table over keys of one to eight bytes, top level.
// Depends on lpht_pkg, lpht_modmac and lpht_ram.
//
// The block stores keys in an open-addressing table of table_length slots
// and, for each input word, either inserts the key at the first free slot
// from its home slot onward or searches for it, returning one result word
// with status, slot and probe count. The home slot is a polynomial hash of
// the key characters in base 37, reduced modulo the table length. Every
// modular product of that hash runs through one shared multiply-accumulate
// unit that takes one multiplier bit per cycle; a key of n characters needs
// 2n-1 such operations. Each probe is one read of the slot memory and one
// compare. The block takes one word at a time and holds in_stall high
// while it works. A finished result sits in an output register, so the
// next word can be taken while the previous result is still stalled.
// After reset the block clears the slot valid bits in memory, one slot
// per cycle, and stalls input words until that pass is done.
// The user must write table_length (cfg_write_enable/cfg_write_data)
// only while the block is idle; the block itself does not enforce this.
// Zero acts as one and values above TABLE_SLOTS act as TABLE_SLOTS. The
// key length is clamped to one through eight characters, and bytes above
// it are ignored.
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_enable,
  input  logic [TABLE_LENGTH_W-1:0] cfg_write_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      mode,
  input  logic [KEY_W-1:0]          key_bytes,
  input  logic [KEY_LEN_W-1:0]      key_length,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_W-1:0]       status,
  output logic [SLOT_W-1:0]         slot,
  output logic [PROBE_COUNT_W-1:0]  probe_count
);

  // Address width for the slots, and value width for lengths and counts,
  // which must also hold TABLE_SLOTS itself.
  localparam int AW    = $clog2(TABLE_SLOTS);
  localparam int LW    = $clog2(TABLE_SLOTS + 1);
  localparam int CW    = (LW > TABLE_LENGTH_W) ? LW : TABLE_LENGTH_W;
  localparam int RAM_W = 1 + KEY_LEN_W + KEY_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_MUL,
    S_HASH_W,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_EMIT
  } state_t;

  state_t state;

  logic [TABLE_LENGTH_W-1:0] table_length_q;

  // Operation context.
  mode_t               mode_q;
  logic [KEY_W-1:0]    key_q;
  logic [KEY_W-1:0]    key_sh;
  logic [KEY_LEN_W-1:0] n_q;
  logic [KEY_LEN_W-1:0] chars_left;
  logic [LW-1:0]       len_q;
  logic [LW-1:0]       sum;
  logic [LW-1:0]       weight;
  logic                op_w;
  logic [AW-1:0]       home_q;
  logic [AW-1:0]       addr;
  logic [LW-1:0]       probes;

  // Pending result.
  status_t             res_status;
  logic [AW-1:0]       res_slot;
  logic [LW-1:0]       res_count;

  // Shared arithmetic unit.
  logic                mac_start;
  logic                mac_start_next;
  logic                mac_done;
  logic [LW-1:0]       mac_result;
  logic [CHAR_W-1:0]   mac_mplier;
  logic [LW-1:0]       mac_addend;

  // Slot memory: {valid, key length, key}.
  logic                ram_we;
  logic [RAM_W-1:0]    ram_wdata;
  logic [RAM_W-1:0]    rdata;
  logic                rd_valid;
  logic [KEY_LEN_W-1:0] rd_len;
  logic [KEY_W-1:0]    rd_key;

  logic [CW-1:0]       tl_ext;
  logic [LW-1:0]       len_eff;
  logic [KEY_LEN_W-1:0] n_eff;
  logic [KEY_W-1:0]    key_in_masked;
  logic [LW-1:0]       addr_inc;
  logic [AW-1:0]       addr_next;
  logic                key_match;
  logic                out_free;
  logic                out_valid_next;

  // Effective table length and key length, clamped into their legal ranges.
  always_comb begin
    tl_ext = CW'(table_length_q);
    if (tl_ext == '0) begin
      len_eff = LW'(1);
    end else if (tl_ext > CW'(TABLE_SLOTS)) begin
      len_eff = LW'(TABLE_SLOTS);
    end else begin
      len_eff = LW'(tl_ext);
    end

    if (key_length == '0) begin
      n_eff = KEY_LEN_W'(1);
    end else if (key_length > KEY_CHARS_L) begin
      n_eff = KEY_CHARS_L;
    end else begin
      n_eff = key_length;
    end
    key_in_masked = key_bytes & key_mask(n_eff);
  end

  // Probing walks forward and wraps at the table length.
  always_comb begin
    addr_inc  = LW'(addr) + LW'(1);
    addr_next = (addr_inc == len_q) ? '0 : AW'(addr_inc);
  end

  assign rd_valid  = rdata[RAM_W-1];
  assign rd_len    = rdata[KEY_W +: KEY_LEN_W];
  assign rd_key    = rdata[KEY_W-1:0];
  assign key_match = rd_valid && (rd_len == n_q) && (rd_key == key_q);

  // The clearing pass writes an invalid word to every slot; an insert
  // writes the key into the free slot it has just found.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {1'b1, n_q, key_q};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else if (state == S_PROBE_CHK && mode_q == MODE_INSERT && !rd_valid) begin
      ram_we = 1'b1;
    end
  end

  // Each character step is sum = (sum + c * w) mod L; between characters
  // the weight advances as w = (w * 37) mod L. Characters go low byte first.
  assign mac_mplier = op_w ? HASH_MULT : key_sh[CHAR_W-1:0];
  assign mac_addend = op_w ? '0 : sum;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // The arithmetic unit is kicked off when a word is taken, after every
  // product except the last character's, and after every weight update.
  always_comb begin
    mac_start_next = 1'b0;
    if (state == S_IDLE) begin
      mac_start_next = in_valid && !in_stall;
    end else if (state == S_HASH_MUL) begin
      mac_start_next = mac_done && (chars_left != KEY_LEN_W'(1));
    end else if (state == S_HASH_W) begin
      mac_start_next = mac_done;
    end
  end

  // A result word stays valid while it is stalled and is replaced by the
  // next one as soon as the output register is free.
  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (state == S_EMIT && out_free) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      addr           <= '0;
      out_valid      <= 1'b0;
      mac_start      <= 1'b0;
      table_length_q <= TABLE_LENGTH_RESET;
    end else begin
      mac_start <= mac_start_next;
      out_valid <= out_valid_next;
      if (cfg_write_enable) begin
        table_length_q <= cfg_write_data;
      end

      unique case (state)
        S_CLEAR: begin
          if (addr == AW'(TABLE_SLOTS - 1)) begin
            addr  <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_valid && !in_stall) begin
            mode_q     <= mode_t'(mode);
            key_q      <= key_in_masked;
            key_sh     <= key_in_masked;
            n_q        <= n_eff;
            chars_left <= n_eff;
            len_q      <= len_eff;
            sum        <= '0;
            weight     <= LW'(1);
            op_w       <= 1'b0;
            state      <= S_HASH_MUL;
          end
        end

        S_HASH_MUL: begin
          if (mac_done) begin
            sum        <= mac_result;
            key_sh     <= key_sh >> CHAR_W;
            chars_left <= chars_left - 1'b1;
            if (chars_left == KEY_LEN_W'(1)) begin
              home_q <= AW'(mac_result);
              addr   <= AW'(mac_result);
              probes <= LW'(1);
              state  <= S_PROBE_RD;
            end else begin
              op_w      <= 1'b1;
              state     <= S_HASH_W;
            end
          end
        end

        S_HASH_W: begin
          if (mac_done) begin
            weight    <= mac_result;
            op_w      <= 1'b0;
            state     <= S_HASH_MUL;
          end
        end

        S_PROBE_RD: begin
          state <= S_PROBE_CHK;
        end

        S_PROBE_CHK: begin
          if (mode_q == MODE_INSERT) begin
            if (!rd_valid) begin
              res_status <= ST_OK;
              res_slot   <= addr;
              res_count  <= probes;
              state      <= S_EMIT;
            end else if (probes == len_q) begin
              res_status <= ST_FULL;
              res_slot   <= '0;
              res_count  <= '0;
              state      <= S_EMIT;
            end else begin
              addr   <= addr_next;
              probes <= probes + 1'b1;
              state  <= S_PROBE_RD;
            end
          end else begin
            // A free slot ends the search, the home slot included; so does
            // wrapping around to the home slot.
            if (!rd_valid || (!key_match && addr_next == home_q)) begin
              res_status <= ST_NOT_FOUND;
              res_slot   <= '0;
              res_count  <= '0;
              state      <= S_EMIT;
            end else if (key_match) begin
              res_status <= ST_OK;
              res_slot   <= addr;
              res_count  <= probes;
              state      <= S_EMIT;
            end else begin
              addr   <= addr_next;
              probes <= probes + 1'b1;
              state  <= S_PROBE_RD;
            end
          end
        end

        S_EMIT: begin
          if (out_free) begin
            status      <= res_status;
            slot        <= SLOT_W'(res_slot);
            probe_count <= PROBE_COUNT_W'(res_count);
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  lpht_modmac #(
    .VW(LW)
  ) u_modmac (
    .clk     (clk),
    .rst     (rst),
    .start   (mac_start),
    .modulus (len_q),
    .mcand   (weight),
    .mplier  (mac_mplier),
    .addend  (mac_addend),
    .done    (mac_done),
    .result  (mac_result)
  );

  lpht_ram #(
    .WIDTH(RAM_W),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  // The arithmetic unit only finishes while the hash is being computed.
  a_mac_done_in_hash: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == S_HASH_MUL || state == S_HASH_W))
    else $error("hash unit finished outside the hash states");

  // The probe count never exceeds the table length.
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_CHK) |-> (probes != '0 && probes <= len_q))
    else $error("probe count out of range");

  // Every probed slot lies inside the table in use.
  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_RD) |-> (LW'(addr) < len_q))
    else $error("probe address beyond table length");

  // A full table is reported only for an insert.
  a_full_only_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && res_status == ST_FULL) |-> (mode_q == MODE_INSERT))
    else $error("table full reported for a search");

endmodule

### hw/rtl/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the slot store of the hash table.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/lpht_modmac.sv
// Iterative modular multiply-accumulate: result = (addend + mcand * mplier) mod modulus.
// Depends on lpht_pkg. Takes one multiplier bit per cycle, then adds the addend.
module lpht_modmac import lpht_pkg::*; #(
  parameter int VW = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [VW-1:0]     modulus,
  input  logic [VW-1:0]     mcand,
  input  logic [CHAR_W-1:0] mplier,
  input  logic [VW-1:0]     addend,
  output logic              done,
  output logic [VW-1:0]     result
);

  localparam int STEP_W = $clog2(CHAR_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CHAR_W);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [VW-1:0]     acc;
  logic [VW-1:0]     mod_q;
  logic [VW-1:0]     mcand_q;
  logic [CHAR_W-1:0] mpl_q;
  logic [VW-1:0]     addend_q;

  logic          add_phase;
  logic [VW:0]   mod_ext;
  logic [VW:0]   dbl;
  logic [VW:0]   dbl_red;
  logic [VW:0]   base;
  logic [VW-1:0] operand;
  logic [VW:0]   sum_raw;
  logic [VW:0]   sum_red;

  // Both the doubled accumulator and the sum stay below twice the modulus,
  // so one conditional subtract reduces each of them.
  always_comb begin
    add_phase = (step == LAST_STEP);
    mod_ext   = {1'b0, mod_q};
    dbl       = {acc, 1'b0};
    dbl_red   = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
    base      = add_phase ? {1'b0, acc} : dbl_red;
    operand   = add_phase ? addend_q : (mpl_q[CHAR_W-1] ? mcand_q : '0);
    sum_raw   = base + {1'b0, operand};
    sum_red   = (sum_raw >= mod_ext) ? sum_raw - mod_ext : sum_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= !start && running && add_phase;
      if (start) begin
        mod_q    <= modulus;
        mcand_q  <= mcand;
        mpl_q    <= mplier;
        addend_q <= addend;
        acc      <= '0;
        step     <= '0;
        running  <= 1'b1;
      end else if (running) begin
        acc   <= sum_red[VW-1:0];
        mpl_q <= {mpl_q[CHAR_W-2:0], 1'b0};
        if (add_phase) begin
          running <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign result = acc;

endmodule
